// File: src/hough_line_accumulator_defines.svh
// Assertion macros shared by the Hough line accumulator RTL.
// No dependencies; included by the top level only.
`ifndef HOUGH_LINE_ACCUMULATOR_DEFINES_SVH
`define HOUGH_LINE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define HLA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hough_line_accumulator: check failed");

// next-cycle implication
`define HLA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hough_line_accumulator: check failed");

`endif

// File: src/hla_pkg.sv
// Constants, types and the angle table of the Hough line accumulator.
// No dependencies; used by hough_line_accumulator.sv.
package hla_pkg;

   localparam int ANGLE_STEPS = 90;
   localparam int RHO_BINS    = 90;
   localparam int COUNT_BITS  = 16;

   localparam int ROW_LEN = RHO_BINS + 2;          // underflow + bins + overflow
   localparam int CELLS   = ANGLE_STEPS * ROW_LEN;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int ANG_W   = $clog2(ANGLE_STEPS);
   localparam int BIN_W   = $clog2(ROW_LEN);

   // input item kinds (tuser)
   localparam logic [1:0] KIND_ACCUM = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic CSR_RHO_MIN   = 1'b0;
   localparam logic CSR_BIN_RECIP = 1'b1;

   localparam logic signed [16:0] RHO_MIN_RESET   = -17'sd5000;
   localparam logic [15:0]        BIN_RECIP_RESET = 16'd197;

   // sin(k deg), k = 0..90, Q1.15 rounded, sin(90) saturated
   localparam logic [15:0] SIN_Q15 [0:90] = '{
      16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
      16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
      16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
      16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
      16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
      16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
      16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
      16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
      16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
      16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
      16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
   };

   // one entry per angle index: {sin, cos}, both signed Q1.15
   typedef logic [ANGLE_STEPS-1:0][31:0] trig_table_type;

   function automatic trig_table_type build_trig();
      trig_table_type t;
      int             i;
      int             deg;
      int             mag;
      logic [15:0]    s;
      logic [15:0]    c;
      t = '0;
      for (i = 0; i < ANGLE_STEPS; i++) begin
         deg = -90 + (180 * i) / ANGLE_STEPS;
         mag = (deg < 0) ? -deg : deg;
         s   = SIN_Q15[mag];
         c   = SIN_Q15[90 - mag];
         if (deg < 0) begin
            s = 16'(16'd0 - s);
         end
         t[i] = {s, c};
      end
      return t;
   endfunction

   localparam trig_table_type TRIG_TABLE = build_trig();

endpackage

// File: src/hla_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; instanced by hough_line_accumulator.sv.
module hla_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/hough_line_accumulator.sv
// Top level of the Hough line accumulator: control, binning pipeline, vote store.
// Depends on hla_pkg.sv, hla_ram.sv and hough_line_accumulator_defines.svh.
//
// Straight-line Hough accumulator. Each req transaction carries a kind in tuser:
// accumulate casts one vote per angle (90 angles, -90..88 deg in 2-deg steps) for
// the point (coord_mm, depth_mm) into a 90 x 92 store of saturating 16-bit counts,
// read returns one cell (zero for indexes out of range) as one rsp transaction,
// clear zeroes the store. Only a read produces a rsp transaction. The block works on
// one item at a time: req_tready is high only when idle. During an accumulate,
// one angle enters the 7-stage binning pipeline per cycle and the single write
// port of the vote memory retires one vote per cycle. A read result shows up on
// rsp after the states ST_RD_ISSUE and ST_RD_WAIT, and waits in ST_RD_WAIT while
// rsp_tready holds the previous result. After reset and after a clear item the
// store is swept to zero, one cell per cycle over all 8280 cells, with req_tready
// low. csr writes are taken at any time but should only be done while idle.
`include "hough_line_accumulator_defines.svh"

module hough_line_accumulator (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // coord_mm[16:0], depth_mm[33:17],
                                    // theta_index[40:34], rho_bin[47:41]
   input  logic [1:0]  req_tuser,   // kind[1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // bin_count[15:0], theta_index_out[22:16],
                                    // rho_bin_out[29:23], zero fill[31:30]

   input  logic        csr_wr_en,
   input  logic        csr_index,   // 0 rho_min_mm, 1 rho_bin_recip
   input  logic [16:0] csr_wdata
);

   localparam int AW = hla_pkg::ADDR_W;
   localparam int BW = hla_pkg::BIN_W;
   localparam int NW = hla_pkg::ANG_W;
   localparam int CW = hla_pkg::COUNT_BITS;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCUM,
      ST_DRAIN,
      ST_RD_ISSUE,
      ST_RD_WAIT
   } state_type;

   // ---------------------------------------------------------------- request fields
   logic               req_accept;
   logic signed [16:0] req_coord;
   logic signed [16:0] req_depth;
   logic [6:0]         req_theta;
   logic [6:0]         req_rho;

   assign req_coord  = req_tdata[16:0];
   assign req_depth  = req_tdata[33:17];
   assign req_theta  = req_tdata[40:34];
   assign req_rho    = req_tdata[47:41];
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------- configuration
   logic signed [16:0] rho_min_ff;
   logic [15:0]        recip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rho_min_ff <= hla_pkg::RHO_MIN_RESET;
         recip_ff   <= hla_pkg::BIN_RECIP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            hla_pkg::CSR_RHO_MIN:   rho_min_ff <= csr_wdata;
            hla_pkg::CSR_BIN_RECIP: recip_ff   <= csr_wdata[15:0];
            default:                ;
         endcase
      end
   end

   // ---------------------------------------------------------------- control state
   state_type          state_ff,    state_in;
   logic [NW-1:0]      ang_ff,      ang_in;       // angle being issued
   logic [AW-1:0]      row_ff,      row_in;       // ang * ROW_LEN
   logic [AW-1:0]      clr_ff,      clr_in;       // sweep address
   logic signed [16:0] pt_x_ff,     pt_x_in;
   logic signed [16:0] pt_z_ff,     pt_z_in;
   logic [AW-1:0]      rd_addr_ff,  rd_addr_in;
   logic               rd_ok_ff,    rd_ok_in;     // read indexes in range
   logic [6:0]         rd_theta_ff, rd_theta_in;
   logic [6:0]         rd_rho_ff,   rd_rho_in;
   logic               rsp_v_ff,    rsp_v_in;
   logic [15:0]        rsp_cnt_ff,  rsp_cnt_in;
   logic [6:0]         rsp_th_ff,   rsp_th_in;
   logic [6:0]         rsp_rb_ff,   rsp_rb_in;

   logic               issue;                     // an angle enters the pipeline
   logic [7:1]         pipe_v_ff;
   logic [CW-1:0]      ram_rd_data;

   always_comb begin
      state_in    = state_ff;
      ang_in      = ang_ff;
      row_in      = row_ff;
      clr_in      = clr_ff;
      pt_x_in     = pt_x_ff;
      pt_z_in     = pt_z_ff;
      rd_addr_in  = rd_addr_ff;
      rd_ok_in    = rd_ok_ff;
      rd_theta_in = rd_theta_ff;
      rd_rho_in   = rd_rho_ff;
      rsp_v_in    = rsp_v_ff && !rsp_tready;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_th_in   = rsp_th_ff;
      rsp_rb_in   = rsp_rb_ff;
      issue       = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(hla_pkg::CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  hla_pkg::KIND_ACCUM: begin
                     pt_x_in  = req_coord;
                     pt_z_in  = req_depth;
                     ang_in   = '0;
                     row_in   = '0;
                     state_in = ST_ACCUM;
                  end
                  hla_pkg::KIND_READ: begin
                     rd_ok_in    = (32'(req_theta) < hla_pkg::ANGLE_STEPS) &&
                                   (32'(req_rho) < hla_pkg::ROW_LEN);
                     rd_addr_in  = AW'(req_theta) * AW'(hla_pkg::ROW_LEN) + AW'(req_rho);
                     rd_theta_in = req_theta;
                     rd_rho_in   = req_rho;
                     state_in    = ST_RD_ISSUE;
                  end
                  hla_pkg::KIND_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;   // unused kind: nothing happens
               endcase
            end
         end
         ST_ACCUM: begin
            issue = 1'b1;
            if (ang_ff == NW'(hla_pkg::ANGLE_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               ang_in = ang_ff + NW'(1);
               row_in = row_ff + AW'(hla_pkg::ROW_LEN);
            end
         end
         ST_DRAIN: begin
            if (pipe_v_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_ISSUE: begin
            state_in = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            // read data holds in the RAM output register until the slot frees
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in   = 1'b1;
               rsp_cnt_in = rd_ok_ff ? 16'(ram_rd_data) : 16'd0;
               rsp_th_in  = rd_theta_ff;
               rsp_rb_in  = rd_rho_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         ang_ff   <= '0;
         row_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ang_ff   <= ang_in;
         row_ff   <= row_in;
         rsp_v_ff <= rsp_v_in;
      end
      pt_x_ff     <= pt_x_in;
      pt_z_ff     <= pt_z_in;
      rd_addr_ff  <= rd_addr_in;
      rd_ok_ff    <= rd_ok_in;
      rd_theta_ff <= rd_theta_in;
      rd_rho_ff   <= rd_rho_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_th_ff   <= rsp_th_in;
      rsp_rb_ff   <= rsp_rb_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {2'b00, rsp_rb_ff, rsp_th_ff, rsp_cnt_ff};

   // ---------------------------------------------------------------- binning pipeline
   // 1: sin/cos lookup  2: x*cos, z*sin  3: rho  4: rho - rho_min
   // 5: partial products with recip  6: bin select, memory read  7: write back
   logic [31:0]        trig;
   logic signed [15:0] sin1_ff, cos1_ff;
   logic [AW-1:0]      row1_ff, row2_ff, row3_ff, row4_ff, row5_ff, row6_ff;
   logic signed [32:0] px2_ff, pz2_ff;
   logic signed [33:0] rho3_ff;
   logic [34:0]        d4_ff;
   logic               neg5_ff;
   logic [32:0]        hp5_ff, lp5_ff;
   logic [50:0]        sum6;
   logic [19:0]        q6;
   logic [BW-1:0]      bin6_in, bin6_ff;
   logic [AW-1:0]      acc_rd_addr;
   logic [AW-1:0]      addr7_ff;
   logic [31:0]        rmin_sh;

   assign trig    = hla_pkg::TRIG_TABLE[ang_ff];
   assign rmin_sh = {rho_min_ff, 15'd0};            // rho_min in Q.15 mm

   // q = floor(d * recip / 2^31), d split into two 17-bit halves
   assign sum6 = {1'b0, hp5_ff, 17'd0} + {18'd0, lp5_ff};
   assign q6   = sum6[50:31];

   always_comb begin
      if (neg5_ff) begin
         bin6_in = '0;                              // underflow
      end else if (q6 >= 20'(hla_pkg::RHO_BINS)) begin
         bin6_in = BW'(hla_pkg::RHO_BINS + 1);      // overflow
      end else begin
         bin6_in = BW'(q6) + BW'(1);
      end
   end

   assign acc_rd_addr = row6_ff + AW'(bin6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
      end else begin
         pipe_v_ff <= {pipe_v_ff[6:1], issue};
      end
      sin1_ff  <= trig[31:16];
      cos1_ff  <= trig[15:0];
      row1_ff  <= row_ff;
      px2_ff   <= 33'(pt_x_ff) * 33'(cos1_ff);
      pz2_ff   <= 33'(pt_z_ff) * 33'(sin1_ff);
      row2_ff  <= row1_ff;
      rho3_ff  <= 34'(px2_ff) + 34'(pz2_ff);
      row3_ff  <= row2_ff;
      d4_ff    <= {rho3_ff[33], rho3_ff} - {{3{rmin_sh[31]}}, rmin_sh};
      row4_ff  <= row3_ff;
      neg5_ff  <= d4_ff[34];
      hp5_ff   <= 33'(d4_ff[33:17]) * 33'(recip_ff);
      lp5_ff   <= 33'(d4_ff[16:0]) * 33'(recip_ff);
      row5_ff  <= row4_ff;
      bin6_ff  <= bin6_in;
      row6_ff  <= row5_ff;
      addr7_ff <= acc_rd_addr;
   end

   // ---------------------------------------------------------------- vote store
   // Votes of one point all land in different rows, so a read never meets a
   // pending write to the same cell; points do not overlap (drain before idle).
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [CW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = pipe_v_ff[7];
         ram_wr_addr = addr7_ff;
         ram_wr_data = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + CW'(1);
      end
      if (state_ff == ST_RD_ISSUE) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = rd_addr_ff;
      end else begin
         ram_rd_en   = pipe_v_ff[6];
         ram_rd_addr = acc_rd_addr;
      end
   end

   hla_ram #(
      .WIDTH (CW),
      .DEPTH (hla_pkg::CELLS)
   ) u_vote_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- assertions
   `HLA_ASSERT_NOW(a_no_rmw_overlap, pipe_v_ff[6] && pipe_v_ff[7], acc_rd_addr != addr7_ff)
   `HLA_ASSERT_NOW(a_idle_drained, req_tready, pipe_v_ff == '0)
   `HLA_ASSERT_NOW(a_sweep_quiet, state_ff == ST_CLEAR, pipe_v_ff == '0 && !ram_rd_en)
   `HLA_ASSERT_NEXT(a_rsp_from_read, !rsp_v_ff && state_ff != ST_RD_WAIT, !rsp_v_ff)

endmodule
